// File: hw/rtl/sce_pkg.sv
// sce_pkg: word types and codes shared by the cumulative seam energy block
// no dependencies; used by every module under hw/rtl
`default_nettype none

package sce_pkg;

    localparam int ENERGY_W = 8;
    localparam int CUM_W    = 16;
    localparam int CFG_W    = 11;

    // choice codes
    localparam logic [1:0] CHOICE_LEFT   = 2'd0;
    localparam logic [1:0] CHOICE_CENTER = 2'd1;
    localparam logic [1:0] CHOICE_RIGHT  = 2'd2;
    localparam logic [1:0] CHOICE_FIRST  = 2'd3;

    localparam logic [CUM_W-1:0] CUM_MAX = {CUM_W{1'b1}};

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                frame_start;
    } in_word_t;

    typedef struct packed {
        logic [CUM_W-1:0] cumulative;
        logic [1:0]       choice;
        logic             row_end;
    } out_word_t;

    // per-pixel position flags handed from the column control to the add stage
    typedef struct packed {
        logic first_row;
        logic col_first;
        logic col_last;
    } pix_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/sce_row_store.sv
// sce_row_store: previous-row cumulative store, two identical copies giving three read ports
// depends on sce_pkg; read data registered, same-cycle write forwarded to the reads
`default_nettype none

module sce_row_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [sce_pkg::CUM_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr_center,
    input  wire logic [AW-1:0]             rd_addr_right,
    input  wire logic [AW-1:0]             rd_addr_wrap,
    output logic [sce_pkg::CUM_W-1:0]      rd_center,
    output logic [sce_pkg::CUM_W-1:0]      rd_right,
    output logic [sce_pkg::CUM_W-1:0]      rd_wrap
);

    // main copy serves center and right, the second copy serves the wrap-around left
    logic [sce_pkg::CUM_W-1:0] mem_main [DEPTH];
    logic [sce_pkg::CUM_W-1:0] mem_wrap [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_main[wr_addr] <= wr_data;
            mem_wrap[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_center <= (wr_en && (wr_addr == rd_addr_center)) ? wr_data
                                                                 : mem_main[rd_addr_center];
            rd_right  <= (wr_en && (wr_addr == rd_addr_right)) ? wr_data
                                                                : mem_main[rd_addr_right];
            rd_wrap   <= (wr_en && (wr_addr == rd_addr_wrap)) ? wr_data
                                                               : mem_wrap[rd_addr_wrap];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sce_col_ctrl.sv
// sce_col_ctrl: row width register, column counter and row-store read addresses
// depends on sce_pkg (config width, pix_ctrl_t)
`default_nettype none

module sce_col_ctrl #(
    parameter int ROW_MAX = 1024,
    parameter int AW      = 10
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [sce_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                      accept,
    input  wire logic                      frame_start,
    output logic [AW-1:0]                  col,
    output sce_pkg::pix_ctrl_t             ctrl,
    output logic [AW-1:0]                  addr_right,
    output logic [AW-1:0]                  addr_wrap
);

    localparam int          WIDE_W     = 13;
    localparam int          RESET_LAST = ((ROW_MAX < 1024) ? ROW_MAX : 1024) - 1;
    localparam logic [WIDE_W-1:0] ROW_MAX_WIDE = WIDE_W'(ROW_MAX);

    logic [AW-1:0]     last_reg;
    logic [AW-1:0]     last_next;
    logic [AW-1:0]     column_count_reg;
    logic [AW-1:0]     column_count_next;
    logic              in_first_row_reg;
    logic              in_first_row_next;
    logic [WIDE_W-1:0] cfg_wide;
    logic [WIDE_W-1:0] last_wide;
    logic [AW-1:0]     col_raw;
    logic              first_row;
    logic              col_last;

    // width zero acts as one, width above the store depth acts as the depth
    always_comb begin
        cfg_wide = {{(WIDE_W-sce_pkg::CFG_W){1'b0}}, cfg_wr_data};
        if (cfg_wide == '0) begin
            last_wide = '0;
        end else if (cfg_wide > ROW_MAX_WIDE) begin
            last_wide = ROW_MAX_WIDE - WIDE_W'(1);
        end else begin
            last_wide = cfg_wide - WIDE_W'(1);
        end
        last_next = last_wide[AW-1:0];
    end

    always_comb begin
        col_raw   = frame_start ? '0 : column_count_reg;
        first_row = frame_start | in_first_row_reg;
        col       = (col_raw > last_reg) ? last_reg : col_raw;
        col_last  = (col == last_reg);

        ctrl.first_row = first_row;
        ctrl.col_first = (col == '0);
        ctrl.col_last  = col_last;

        addr_right = col_last ? '0 : col + AW'(1);
        addr_wrap  = last_reg;

        column_count_next = col_last ? '0 : col + AW'(1);
        in_first_row_next = col_last ? 1'b0 : first_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg         <= AW'(RESET_LAST);
            column_count_reg <= '0;
            in_first_row_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                last_reg <= last_next;
            end
            if (accept) begin
                column_count_reg <= column_count_next;
                in_first_row_reg <= in_first_row_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sce_cum_unit.sv
// sce_cum_unit: neighbour minimum, saturating add, row-store write back and output register
// depends on sce_pkg (codes, word types); takes read data from sce_row_store
`default_nettype none

module sce_cum_unit #(
    parameter int AW = 10
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_load,
    input  wire logic [sce_pkg::ENERGY_W-1:0] in_energy,
    input  wire sce_pkg::pix_ctrl_t           in_ctrl,
    input  wire logic [AW-1:0]                in_col,
    input  wire logic [sce_pkg::CUM_W-1:0]    rd_center,
    input  wire logic [sce_pkg::CUM_W-1:0]    rd_right,
    input  wire logic [sce_pkg::CUM_W-1:0]    rd_wrap,
    input  wire logic                         m_ready,
    output logic                              load_ready,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [sce_pkg::CUM_W-1:0]         wr_data,
    output logic                              out_valid,
    output sce_pkg::out_word_t                out_data
);

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [sce_pkg::ENERGY_W-1:0] s1_energy_reg;
    sce_pkg::pix_ctrl_t           s1_ctrl_reg;
    logic [AW-1:0]                s1_col_reg;
    logic [sce_pkg::CUM_W-1:0]    saved_left_reg;
    logic [sce_pkg::CUM_W-1:0]    saved_first_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    sce_pkg::out_word_t           out_data_reg;

    logic                         advance;
    logic [sce_pkg::CUM_W-1:0]    left;
    logic [sce_pkg::CUM_W-1:0]    right;
    logic [sce_pkg::CUM_W-1:0]    best;
    logic [1:0]                   choice;
    logic [sce_pkg::CUM_W:0]      sum;
    logic [sce_pkg::CUM_W-1:0]    cum;

    assign advance    = s1_valid_reg && (!out_valid_reg || m_ready);
    assign load_ready = !s1_valid_reg || advance;

    always_comb begin
        // wrap-around neighbours: column 0 looks at the last column, the last at column 0
        left  = s1_ctrl_reg.col_first ? rd_wrap : saved_left_reg;
        right = (s1_ctrl_reg.col_last && !s1_ctrl_reg.col_first) ? saved_first_reg : rd_right;

        priority if (s1_ctrl_reg.first_row) begin
            best   = '0;
            choice = sce_pkg::CHOICE_FIRST;
        end else if ((left <= rd_center) && (left <= right)) begin
            best   = left;
            choice = sce_pkg::CHOICE_LEFT;
        end else if (rd_center <= right) begin
            best   = rd_center;
            choice = sce_pkg::CHOICE_CENTER;
        end else begin
            best   = right;
            choice = sce_pkg::CHOICE_RIGHT;
        end

        sum = {1'b0, best} + {{(sce_pkg::CUM_W+1-sce_pkg::ENERGY_W){1'b0}}, s1_energy_reg};
        cum = sum[sce_pkg::CUM_W] ? sce_pkg::CUM_MAX : sum[sce_pkg::CUM_W-1:0];
    end

    assign wr_en   = advance;
    assign wr_addr = s1_col_reg;
    assign wr_data = cum;

    always_comb begin
        s1_valid_next = in_load ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            saved_left_reg  <= '0;
            saved_first_reg <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                saved_left_reg <= rd_center;
                if (s1_ctrl_reg.col_first) begin
                    saved_first_reg <= rd_center;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            s1_energy_reg <= in_energy;
            s1_ctrl_reg   <= in_ctrl;
            s1_col_reg    <= in_col;
        end
        if (advance) begin
            out_data_reg.cumulative <= cum;
            out_data_reg.choice     <= choice;
            out_data_reg.row_end    <= s1_ctrl_reg.col_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/seam_cumulative_energy.sv
// Cumulative seam energy over a pixel stream, bottom image row first. One word is taken
// per clock while the result side keeps up: the row store is read in the cycle a word is
// accepted, and the compare and saturating add then work on the registered word and reads;
// the result is registered and held until the result side takes it. The store has no
// clearing pass; rows must be fed from a frame start so that every column read was written.
// The row width register may be written only while the block is idle.
// Depends on sce_pkg, sce_col_ctrl, sce_row_store and sce_cum_unit.
`default_nettype none

module seam_cumulative_energy #(
    parameter int ROW_MAX = 1024
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [sce_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire sce_pkg::in_word_t         s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output sce_pkg::out_word_t             m_data
);

    localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

    logic                      accept;
    logic [AW-1:0]             col;
    sce_pkg::pix_ctrl_t        ctrl;
    logic [AW-1:0]             addr_right;
    logic [AW-1:0]             addr_wrap;
    logic [sce_pkg::CUM_W-1:0] rd_center;
    logic [sce_pkg::CUM_W-1:0] rd_right;
    logic [sce_pkg::CUM_W-1:0] rd_wrap;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [sce_pkg::CUM_W-1:0] wr_data;

    assign accept = s_valid && s_ready;

    sce_col_ctrl #(
        .ROW_MAX (ROW_MAX),
        .AW      (AW)
    ) u_col_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .frame_start (s_data.frame_start),
        .col         (col),
        .ctrl        (ctrl),
        .addr_right  (addr_right),
        .addr_wrap   (addr_wrap)
    );

    sce_row_store #(
        .DEPTH (ROW_MAX),
        .AW    (AW)
    ) u_row_store (
        .aclk           (aclk),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (accept),
        .rd_addr_center (col),
        .rd_addr_right  (addr_right),
        .rd_addr_wrap   (addr_wrap),
        .rd_center      (rd_center),
        .rd_right       (rd_right),
        .rd_wrap        (rd_wrap)
    );

    sce_cum_unit #(
        .AW (AW)
    ) u_cum_unit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_load    (accept),
        .in_energy  (s_data.energy),
        .in_ctrl    (ctrl),
        .in_col     (col),
        .rd_center  (rd_center),
        .rd_right   (rd_right),
        .rd_wrap    (rd_wrap),
        .m_ready    (m_ready),
        .load_ready (s_ready),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (m_valid),
        .out_data   (m_data)
    );

endmodule

`default_nettype wire
